FILE: hdl/gated_ema_sensor_filter_defines.svh
// Assertion macros shared by the gated EMA sensor filter RTL.
`ifndef GATED_EMA_SENSOR_FILTER_DEFINES_SVH
`define GATED_EMA_SENSOR_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GEMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GEMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/gema_pkg.sv
// Package: widths, codes and shared types of the gated EMA sensor filter.
`default_nettype none

package gema_pkg;

   // Sample format and accumulator layout
   localparam int SAMPLE_W      = 16;
   localparam int FRACTION_BITS = 8;
   localparam int ACC_W         = SAMPLE_W + FRACTION_BITS;

   // Smoothing weight is in 1/256 units
   localparam int WEIGHT_W     = 9;
   localparam int WEIGHT_SHIFT = 8;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(1 << WEIGHT_SHIFT);

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_TEMP_LOW   = 3'd0,
      REG_TEMP_HIGH  = 3'd1,
      REG_HUMID_LOW  = 3'd2,
      REG_HUMID_HIGH = 3'd3,
      REG_WEIGHT     = 3'd4
   } reg_index_type;

   localparam logic signed [SAMPLE_W-1:0] TEMP_LOW_RESET   = -16'sd4000;
   localparam logic signed [SAMPLE_W-1:0] TEMP_HIGH_RESET  = 16'sd8500;
   localparam logic signed [SAMPLE_W-1:0] HUMID_LOW_RESET  = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] HUMID_HIGH_RESET = 16'sd10000;
   localparam logic [WEIGHT_W-1:0]        WEIGHT_RESET     = 9'd51;

   // Source status codes on the input
   localparam logic [1:0] SRC_PRESENT   = 2'd0;
   localparam logic [1:0] SRC_NOT_SETUP = 2'd1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_SETUP = 2'd1,
      ST_READ_FAIL = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] temp_low;
      logic signed [SAMPLE_W-1:0] temp_high;
      logic signed [SAMPLE_W-1:0] humid_low;
      logic signed [SAMPLE_W-1:0] humid_high;
      logic [WEIGHT_W-1:0]        weight;
   } cfg_type;

   // Accumulator controls for one lane
   typedef struct packed {
      logic seed;
      logic update;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/gema_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module gema_csr
   import gema_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Register writes; addresses past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_TEMP_LOW:   cfg_in.temp_low   = csr_pwdata[SAMPLE_W-1:0];
            REG_TEMP_HIGH:  cfg_in.temp_high  = csr_pwdata[SAMPLE_W-1:0];
            REG_HUMID_LOW:  cfg_in.humid_low  = csr_pwdata[SAMPLE_W-1:0];
            REG_HUMID_HIGH: cfg_in.humid_high = csr_pwdata[SAMPLE_W-1:0];
            REG_WEIGHT:     cfg_in.weight     = csr_pwdata[WEIGHT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low   <= TEMP_LOW_RESET;
         cfg_ff.temp_high  <= TEMP_HIGH_RESET;
         cfg_ff.humid_low  <= HUMID_LOW_RESET;
         cfg_ff.humid_high <= HUMID_HIGH_RESET;
         cfg_ff.weight     <= WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back, signed limits sign-extended
   always_comb begin
      case (index)
         REG_TEMP_LOW:   csr_prdata = CSR_DATA_W'(cfg_ff.temp_low);
         REG_TEMP_HIGH:  csr_prdata = CSR_DATA_W'(cfg_ff.temp_high);
         REG_HUMID_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.humid_low);
         REG_HUMID_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.humid_high);
         REG_WEIGHT:     csr_prdata = CSR_DATA_W'(cfg_ff.weight);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/gema_lane.sv
// One filter channel: accumulator register and its seed/EMA update.
`default_nettype none

module gema_lane
   import gema_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_ctrl_type              ctrl,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic [WEIGHT_W-1:0]        weight,
   output logic signed [ACC_W-1:0]         acc_next
);

   localparam int DIFF_W = ACC_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W-1:0]    target;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [WEIGHT_W:0]   weight_s;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   step;

   // Reading moved onto the fixed-point grid
   assign target   = {sample, {FRACTION_BITS{1'b0}}};
   assign diff     = DIFF_W'(target) - DIFF_W'(acc_ff);
   assign weight_s = signed'({1'b0, weight});

   // acc + floor(w * (target - acc) / 256); result stays between acc and target
   assign prod = PROD_W'(diff) * PROD_W'(weight_s);
   assign step = prod >>> WEIGHT_SHIFT;

   always_comb begin
      if (ctrl.seed) begin
         acc_in = target;
      end else if (ctrl.update) begin
         acc_in = acc_ff + step[ACC_W-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc_next = acc_in;

endmodule

`default_nettype wire

FILE: hdl/gated_ema_sensor_filter.sv
// Top level of the gated EMA sensor filter: input register, gating, two lanes, result register.
// An accepted item passes the input register, then the result register, before its result is shown.
// Throughput: 1 item per cycle unless results stall; each lane's update is one multiply-add.
// A stalled result holds the result register; the input register still takes one item.
// Reset (synchronous, active high) clears both accumulators, the seeded flag, both stage valids
// and loads the register file with its default limits and weight.
`default_nettype none

`include "gated_ema_sensor_filter_defines.svh"

module gated_ema_sensor_filter
   import gema_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_source_status,
   input  wire logic signed [SAMPLE_W-1:0] req_temp_reading,
   input  wire logic signed [SAMPLE_W-1:0] req_humid_reading,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_result_status,
   output logic signed [SAMPLE_W-1:0]      rsp_filtered_temp,
   output logic signed [SAMPLE_W-1:0]      rsp_filtered_humid,
   output logic                            rsp_result_valid,
   // configuration port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [CSR_DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready
);

   cfg_type cfg;

   gema_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- input register ----------------
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [1:0]                 in_src_ff;
   logic signed [SAMPLE_W-1:0] in_temp_ff;
   logic signed [SAMPLE_W-1:0] in_humid_ff;
   logic                       advance;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;

   // Stage moves when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_src_ff   <= req_source_status;
         in_temp_ff  <= req_temp_reading;
         in_humid_ff <= req_humid_reading;
      end
   end

   // ---------------- gating ----------------
   status_type    status;
   logic          in_range;
   logic          good;
   logic          seeded_ff;
   logic          seeded_in;
   logic [WEIGHT_W-1:0] weight_eff;
   lane_ctrl_type lane_ctrl;

   assign in_range = (in_temp_ff  >= cfg.temp_low)  && (in_temp_ff  <= cfg.temp_high) &&
                     (in_humid_ff >= cfg.humid_low) && (in_humid_ff <= cfg.humid_high);

   // Unused source code 3 reports as a read failure
   always_comb begin
      if (in_src_ff == SRC_NOT_SETUP) begin
         status = ST_NOT_SETUP;
      end else if (in_src_ff != SRC_PRESENT) begin
         status = ST_READ_FAIL;
      end else if (!in_range) begin
         status = ST_RANGE;
      end else begin
         status = ST_OK;
      end
   end

   assign good       = advance && (status == ST_OK);
   assign weight_eff = (cfg.weight > WEIGHT_MAX) ? WEIGHT_MAX : cfg.weight;

   // First good item seeds, later ones update
   assign lane_ctrl.seed   = good && !seeded_ff;
   assign lane_ctrl.update = good && seeded_ff;
   assign seeded_in        = seeded_ff || good;

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else begin
         seeded_ff <= seeded_in;
      end
   end

   logic signed [ACC_W-1:0] temp_acc_next;
   logic signed [ACC_W-1:0] humid_acc_next;

   gema_lane u_temp_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .sample   (in_temp_ff),
      .weight   (weight_eff),
      .acc_next (temp_acc_next)
   );

   gema_lane u_humid_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .sample   (in_humid_ff),
      .weight   (weight_eff),
      .acc_next (humid_acc_next)
   );

   // ---------------- result register ----------------
   logic [1:0]                 rsp_status_ff;
   logic signed [SAMPLE_W-1:0] rsp_temp_ff;
   logic signed [SAMPLE_W-1:0] rsp_humid_ff;
   logic                       rsp_ok_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Integer part of the (possibly updated) accumulators
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_temp_ff   <= temp_acc_next[ACC_W-1:FRACTION_BITS];
         rsp_humid_ff  <= humid_acc_next[ACC_W-1:FRACTION_BITS];
         rsp_ok_ff     <= (status == ST_OK);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_status  = rsp_status_ff;
   assign rsp_filtered_temp  = rsp_temp_ff;
   assign rsp_filtered_humid = rsp_humid_ff;
   assign rsp_result_valid   = rsp_ok_ff;

   // ---------------- assertions ----------------
   `GEMA_ASSERT_NOW(a_valid_means_ok, clock, reset,
      rsp_valid_ff && rsp_ok_ff, rsp_status_ff == ST_OK,
      "result flagged valid with a non-ok status")

   `GEMA_ASSERT_NEXT(a_good_seeds, clock, reset,
      good, seeded_ff && rsp_valid_ff && rsp_ok_ff,
      "good item did not leave the filter seeded with a valid result")

   `GEMA_ASSERT_NEXT(a_bad_holds_state, clock, reset,
      !good, temp_acc_next == $past(temp_acc_next) || lane_ctrl.seed || lane_ctrl.update,
      "accumulator moved without a good item")

   `GEMA_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready,
      "input taken while both stages are stalled")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the gated EMA sensor filter: APB setup, directed and random readings.
`timescale 1ns / 1ps

module testbench;
   import gema_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // Source codes with no name in the package
   localparam logic [1:0] SRC_READ_FAIL = 2'd2;
   localparam logic [1:0] SRC_UNUSED    = 2'd3;

   // One filtered pair as the block should return it
   typedef struct {
      status_type                 status;
      logic signed [SAMPLE_W-1:0] temp;
      logic signed [SAMPLE_W-1:0] humid;
      logic                       valid;
   } filter_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_source_status = SRC_PRESENT;
   logic signed [SAMPLE_W-1:0] req_temp_reading = '0;
   logic signed [SAMPLE_W-1:0] req_humid_reading = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_result_status;
   logic signed [SAMPLE_W-1:0] rsp_filtered_temp;
   logic signed [SAMPLE_W-1:0] rsp_filtered_humid;
   logic                       rsp_result_valid;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   // Filter state and register copy kept by the testbench
   logic signed [SAMPLE_W-1:0] cfg_temp_low   = TEMP_LOW_RESET;
   logic signed [SAMPLE_W-1:0] cfg_temp_high  = TEMP_HIGH_RESET;
   logic signed [SAMPLE_W-1:0] cfg_humid_low  = HUMID_LOW_RESET;
   logic signed [SAMPLE_W-1:0] cfg_humid_high = HUMID_HIGH_RESET;
   logic [WEIGHT_W-1:0]        cfg_weight     = WEIGHT_RESET;
   logic signed [ACC_W-1:0]    temp_acc  = '0;
   logic signed [ACC_W-1:0]    humid_acc = '0;
   logic                       seeded    = 1'b0;

   filter_result_type filtered_pairs_due[$];
   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  cycle_count    = 0;
   int  receiver_hold  = 0;
   bit  sender_idles   = 1'b1;
   bit  receiver_idles = 1'b1;

   gated_ema_sensor_filter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_source_status  (req_source_status),
      .req_temp_reading   (req_temp_reading),
      .req_humid_reading  (req_humid_reading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_status  (rsp_result_status),
      .rsp_filtered_temp  (rsp_filtered_temp),
      .rsp_filtered_humid (rsp_filtered_humid),
      .rsp_result_valid   (rsp_result_valid),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // One EMA step: acc + floor(w * (x<<F - acc) / 256)
   function automatic logic signed [ACC_W-1:0] ema_step(input logic signed [ACC_W-1:0] acc,
         input logic signed [SAMPLE_W-1:0] x, input int weight);
      longint target;
      longint delta;
      target = longint'(x) * (longint'(1) << FRACTION_BITS);
      delta  = (longint'(weight) * (target - longint'(acc))) >>> WEIGHT_SHIFT;
      return ACC_W'(longint'(acc) + delta);
   endfunction

   // Gate the reading, update the filter copy and queue the pair it produces
   function automatic void filter_reading(input logic [1:0] src,
         input logic signed [SAMPLE_W-1:0] t, input logic signed [SAMPLE_W-1:0] h);
      filter_result_type res;
      int weight;
      res.valid = 1'b0;
      if (src == SRC_NOT_SETUP)
         res.status = ST_NOT_SETUP;
      else if (src != SRC_PRESENT)
         res.status = ST_READ_FAIL;
      else if (t < cfg_temp_low || t > cfg_temp_high || h < cfg_humid_low || h > cfg_humid_high)
         res.status = ST_RANGE;
      else begin
         res.status = ST_OK;
         res.valid  = 1'b1;
         if (!seeded) begin
            temp_acc  = {t, {FRACTION_BITS{1'b0}}};
            humid_acc = {h, {FRACTION_BITS{1'b0}}};
            seeded    = 1'b1;
         end else begin
            weight    = (cfg_weight > WEIGHT_MAX) ? int'(WEIGHT_MAX) : int'(cfg_weight);
            temp_acc  = ema_step(temp_acc, t, weight);
            humid_acc = ema_step(humid_acc, h, weight);
         end
      end
      res.temp  = temp_acc[ACC_W-1:FRACTION_BITS];
      res.humid = humid_acc[ACC_W-1:FRACTION_BITS];
      filtered_pairs_due.push_back(res);
   endfunction

   // Offer one reading, hold it until taken, then predict its pair
   task automatic send_reading(input logic [1:0] src, input logic signed [SAMPLE_W-1:0] t,
         input logic signed [SAMPLE_W-1:0] h);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_source_status <= src;
      req_temp_reading  <= t;
      req_humid_reading <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filter_reading(src, t, h);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (filtered_pairs_due.size() != 0) @(posedge clock);
   endtask

   // APB transfers leave psel high so the next setup can follow directly
   task automatic write_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_TEMP_LOW:   cfg_temp_low   = value[SAMPLE_W-1:0];
         REG_TEMP_HIGH:  cfg_temp_high  = value[SAMPLE_W-1:0];
         REG_HUMID_LOW:  cfg_humid_low  = value[SAMPLE_W-1:0];
         REG_HUMID_HIGH: cfg_humid_high = value[SAMPLE_W-1:0];
         REG_WEIGHT:     cfg_weight     = value[WEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic read_register(input reg_index_type idx, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
   endtask

   task automatic csr_idle();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input int t_low, input int t_high, input int h_low,
         input int h_high, input int weight);
      write_register(REG_TEMP_LOW, t_low);
      write_register(REG_TEMP_HIGH, t_high);
      write_register(REG_HUMID_LOW, h_low);
      write_register(REG_HUMID_HIGH, h_high);
      write_register(REG_WEIGHT, weight);
      csr_idle();
   endtask

   // Read back every register, compare the bits it implements
   task automatic check_registers();
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] held;
      reg_index_type idx;
      for (int i = 0; i <= int'(REG_WEIGHT); i++) begin
         idx = reg_index_type'(i);
         read_register(idx, word);
         case (idx)
            REG_TEMP_LOW:   held = CSR_DATA_W'(cfg_temp_low);
            REG_TEMP_HIGH:  held = CSR_DATA_W'(cfg_temp_high);
            REG_HUMID_LOW:  held = CSR_DATA_W'(cfg_humid_low);
            REG_HUMID_HIGH: held = CSR_DATA_W'(cfg_humid_high);
            default:        held = CSR_DATA_W'(cfg_weight);
         endcase
         if (idx == REG_WEIGHT) begin
            if (word[WEIGHT_W-1:0] !== held[WEIGHT_W-1:0])
               report_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(),
                  word[WEIGHT_W-1:0], held[WEIGHT_W-1:0]));
         end else if (word[SAMPLE_W-1:0] !== held[SAMPLE_W-1:0]) begin
            report_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(),
               $signed(word[SAMPLE_W-1:0]), $signed(held[SAMPLE_W-1:0])));
         end
      end
      csr_idle();
   endtask

   function automatic int random_sample();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int pick_between(input int lo, input int hi);
      if (lo > hi)
         return random_sample();
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // A limit itself or the value just past it
   function automatic int near_limit(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         2:       return lo - 1;
         default: return hi + 1;
      endcase
   endfunction

   // Mostly good readings inside the window, some random, some at its edges, some faults
   task automatic random_reading(output logic [1:0] src, output logic signed [SAMPLE_W-1:0] t,
         output logic signed [SAMPLE_W-1:0] h);
      int roll;
      roll = $urandom_range(0, 99);
      src  = SRC_PRESENT;
      if (roll < 70) begin
         t = SAMPLE_W'(pick_between(cfg_temp_low, cfg_temp_high));
         h = SAMPLE_W'(pick_between(cfg_humid_low, cfg_humid_high));
      end else if (roll < 80) begin
         t = SAMPLE_W'(random_sample());
         h = SAMPLE_W'(random_sample());
      end else if (roll < 88) begin
         t = SAMPLE_W'(near_limit(cfg_temp_low, cfg_temp_high));
         h = SAMPLE_W'(near_limit(cfg_humid_low, cfg_humid_high));
      end else begin
         src = 2'($urandom_range(1, 3));
         t   = SAMPLE_W'(random_sample());
         h   = SAMPLE_W'(random_sample());
      end
   endtask

   task automatic run_random_readings(input int count);
      logic [1:0] src;
      logic signed [SAMPLE_W-1:0] t;
      logic signed [SAMPLE_W-1:0] h;
      for (int k = 0; k < count; k++) begin
         random_reading(src, t, h);
         send_reading(src, t, h);
      end
      wait_drained();
   endtask

   task automatic shuffle_idling();
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
   endtask

   task automatic configure_random_window(input int weight);
      int a, b, c, d;
      a = random_sample();
      b = random_sample();
      c = random_sample();
      d = random_sample();
      configure(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c, weight);
   endtask

   // Registers come out of reset with their default limits and weight
   task automatic test_register_access();
      check_registers();
   endtask

   // Faults and rejected readings before seeding return a zero pair
   task automatic test_unseeded_errors();
      send_reading(SRC_NOT_SETUP, 16'sd2500, 16'sd5000);
      send_reading(SRC_READ_FAIL, 16'sd2500, 16'sd5000);
      send_reading(SRC_UNUSED, -16'sd1, -16'sd1);
      send_reading(SRC_PRESENT, 16'sd9000, 16'sd5000);
      send_reading(SRC_PRESENT, 16'sd2000, -16'sd1);
      wait_drained();
   endtask

   // Seed on the lower corner, then the inclusive limits and one past each but the low humidity limit
   task automatic test_limit_boundaries();
      send_reading(SRC_PRESENT, -16'sd4000, 16'sd0);
      send_reading(SRC_PRESENT, 16'sd8500, 16'sd10000);
      send_reading(SRC_PRESENT, 16'sd8501, 16'sd5000);
      send_reading(SRC_PRESENT, -16'sd4001, 16'sd5000);
      send_reading(SRC_PRESENT, 16'sd2000, 16'sd10001);
      wait_drained();
   endtask

   // Zero weight holds, full and oversized weight track, smallest weight creeps
   task automatic test_weight_extremes();
      configure(-32768, 32767, -32768, 32767, 0);
      send_reading(SRC_PRESENT, 16'sd32767, -16'sd32768);
      wait_drained();
      configure(-32768, 32767, -32768, 32767, 256);
      send_reading(SRC_PRESENT, 16'sd32767, -16'sd32768);
      send_reading(SRC_PRESENT, -16'sd32768, 16'sd32767);
      wait_drained();
      configure(-32768, 32767, -32768, 32767, 511);
      send_reading(SRC_PRESENT, 16'sd1234, -16'sd1234);
      wait_drained();
      configure(-32768, 32767, -32768, 32767, 1);
      send_reading(SRC_PRESENT, -16'sd32768, 16'sd32767);
      send_reading(SRC_PRESENT, -16'sd1, -16'sd1);
      wait_drained();
      check_registers();
   endtask

   // Low limit above high limit rejects every present reading
   task automatic test_inverted_limits();
      configure(100, -100, 0, 10000, 51);
      send_reading(SRC_PRESENT, 16'sd0, 16'sd5000);
      send_reading(SRC_PRESENT, 16'sd100, 16'sd5000);
      send_reading(SRC_NOT_SETUP, 16'sd0, 16'sd5000);
      wait_drained();
      configure(-4000, 8500, 10000, 0, 51);
      send_reading(SRC_PRESENT, 16'sd2000, 16'sd5000);
      wait_drained();
      check_registers();
   endtask

   // Random readings across a series of register settings
   task automatic test_config_phases();
      shuffle_idling();
      configure(-4000, 8500, 0, 10000, 51);
      run_random_readings(180);
      shuffle_idling();
      configure(-32768, 32767, -32768, 32767, 256);
      run_random_readings(180);
      shuffle_idling();
      configure(-32768, 32767, -32768, 32767, 1);
      run_random_readings(160);
      shuffle_idling();
      configure_random_window(0);
      run_random_readings(160);
      shuffle_idling();
      configure_random_window($urandom_range(257, 511));
      run_random_readings(160);
      // single-value window on both channels
      shuffle_idling();
      begin
         int a, c;
         a = random_sample();
         c = random_sample();
         configure(a, a, c, c, $urandom_range(1, 256));
      end
      run_random_readings(160);
      shuffle_idling();
      configure(1000, -1000, 10000, 0, 128);
      run_random_readings(40);
      shuffle_idling();
      configure_random_window($urandom_range(1, 256));
      run_random_readings(100);
      check_registers();
   endtask

   // Receiver stops for a long stretch while items keep coming
   task automatic test_backpressure();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      configure(-32768, 32767, -32768, 32767, $urandom_range(1, 256));
      receiver_hold = 48;
      run_random_readings(24);
   endtask

   // Back-to-back items with the receiver always ready
   task automatic test_full_rate();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      configure(-32768, 32767, -32768, 32767, $urandom_range(1, 256));
      run_random_readings(250);
   endtask

   // Result side ready control: long hold on request, else short random stalls
   initial begin
      int span;
      forever begin
         @(posedge clock);
         if (receiver_hold > 0) begin
            span          = receiver_hold;
            receiver_hold = 0;
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Compare each returned pair with the oldest one due
   initial begin
      filter_result_type due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (filtered_pairs_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
            end else begin
               due = filtered_pairs_due.pop_front();
               if (rsp_result_status !== due.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                     rsp_result_status, due.status));
               if (rsp_filtered_temp !== due.temp)
                  report_mismatch($sformatf("result %0d temp %0d, want %0d", results_seen,
                     rsp_filtered_temp, due.temp));
               if (rsp_filtered_humid !== due.humid)
                  report_mismatch($sformatf("result %0d humid %0d, want %0d", results_seen,
                     rsp_filtered_humid, due.humid));
               if (rsp_result_valid !== due.valid)
                  report_mismatch($sformatf("result %0d valid %0b, want %0b", results_seen,
                     rsp_result_valid, due.valid));
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_unseeded_errors();
      test_limit_boundaries();
      test_weight_extremes();
      test_inverted_limits();
      test_config_phases();
      test_backpressure();
      test_full_rate();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gema_pkg.sv
hdl/gema_csr.sv
hdl/gema_lane.sv
hdl/gated_ema_sensor_filter.sv
tb/sv/testbench.sv
